>>> rtl/sm3_compression_macros.svh
// ----------------------------------------------------------------------------
// SM3 compression assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SM3_COMPRESSION_MACROS_SVH
`define SM3_COMPRESSION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/sm3c_pkg.sv
// ----------------------------------------------------------------------------
// SM3 compression package
// Shared types, constants and bit functions of the SM3 compression engine.
// ----------------------------------------------------------------------------
package sm3c_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0][31:0] state_vec_t;   // A..H, A in slot 0
  typedef logic [15:0][31:0] window_t;     // schedule line, oldest word in slot 0

  typedef enum logic {
    OP_MESSAGE = 1'b0,
    OP_RESTART = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ROUND,
    S_OUT
  } fsm_t;

  // schedule line control
  typedef struct packed {
    logic shift;    // every cell takes its input; all but the tail take the neighbor's word
    logic expand;   // tail cell takes the expanded word, else the loaded word
  } sched_ctrl_t;

  localparam int unsigned WORDS_PER_BLOCK = 16;
  localparam int unsigned ROUNDS          = 64;
  localparam int unsigned DIGEST_WORDS    = 8;

  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;

  localparam state_vec_t SM3_IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  function automatic word_t rotl(word_t x, logic [4:0] n);
    logic [63:0] y;
    y = {x, x} << n;
    return y[63:32];
  endfunction

  function automatic word_t perm0(word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // round constant already rotated by the round number (a constant table)
  function automatic word_t t_rot(logic [5:0] r);
    return rotl((r[5:4] == 2'b00) ? T_LOW : T_HIGH, r[4:0]);
  endfunction

endpackage

>>> rtl/sm3c_wcell.sv
// ----------------------------------------------------------------------------
// SM3 schedule cell
// One 32-bit word of the message schedule line; takes its input word
// on a shift.
// ----------------------------------------------------------------------------
module sm3c_wcell
  import sm3c_pkg::*;
(
  input  logic  clk,
  input  logic  shift,
  input  word_t d,
  output word_t q
);

  word_t word;

  always_ff @(posedge clk) begin
    if (shift) begin
      word <= d;
    end
  end

  assign q = word;

endmodule

>>> rtl/sm3c_sched.sv
// ----------------------------------------------------------------------------
// SM3 message schedule line
// Sixteen chained cells; loads the block word by word, then expands
// W16..W79 in place, one word per round.
// ----------------------------------------------------------------------------
module sm3c_sched
  import sm3c_pkg::*;
(
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  input  word_t       load_word,
  output window_t     win
);

  window_t cell_in;
  word_t   expanded;

  // W[j+16] from the window W[j..j+15]
  assign expanded = perm1(win[0] ^ win[7] ^ rotl(win[13], 5'd15))
                  ^ rotl(win[3], 5'd7) ^ win[10];

  always_comb begin
    for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
      cell_in[i] = win[i + 1];
    end
    cell_in[WORDS_PER_BLOCK - 1] = ctrl.expand ? expanded : load_word;
  end

  for (genvar g = 0; g < WORDS_PER_BLOCK; g++) begin : g_cell
    sm3c_wcell u_cell (
      .clk   (clk),
      .shift (ctrl.shift),
      .d     (cell_in[g]),
      .q     (win[g])
    );
  end

endmodule

>>> rtl/sm3c_round.sv
// ----------------------------------------------------------------------------
// SM3 round step
// One compression round on A..H with the current schedule words.
// ----------------------------------------------------------------------------
module sm3c_round
  import sm3c_pkg::*;
(
  input  state_vec_t cur,
  input  logic [5:0] r,
  input  word_t      w_j,     // W[j]
  input  word_t      w_j4,    // W[j+4]
  output state_vec_t nxt
);

  word_t a12, ss1, ss2, ff, gg, tt1, tt2;
  logic  low_rounds;

  assign low_rounds = (r[5:4] == 2'b00);
  assign a12 = rotl(cur[0], 5'd12);
  assign ss1 = rotl(a12 + cur[4] + t_rot(r), 5'd7);
  assign ss2 = ss1 ^ a12;
  assign ff  = low_rounds ? (cur[0] ^ cur[1] ^ cur[2])
                          : ((cur[0] & cur[1]) | (cur[0] & cur[2]) | (cur[1] & cur[2]));
  assign gg  = low_rounds ? (cur[4] ^ cur[5] ^ cur[6])
                          : ((cur[4] & cur[5]) | (~cur[4] & cur[6]));
  assign tt1 = ff + cur[3] + ss2 + (w_j ^ w_j4);
  assign tt2 = gg + cur[7] + ss1 + w_j;

  always_comb begin
    nxt[0] = tt1;
    nxt[1] = cur[0];
    nxt[2] = rotl(cur[1], 5'd9);
    nxt[3] = cur[2];
    nxt[4] = perm0(tt2);
    nxt[5] = cur[4];
    nxt[6] = rotl(cur[5], 5'd19);
    nxt[7] = cur[6];
  end

endmodule

>>> rtl/sm3_compression.sv
// ----------------------------------------------------------------------------
// SM3 compression engine
// Takes a padded message as 32-bit words and returns the chaining value
// after every 512-bit block.
// ----------------------------------------------------------------------------
// Send sixteen message items (tuser = 0), most significant word of the block
// first; a restart item (tuser = 1) reloads the SM3 IV and drops any partial
// block. Words are taken one per cycle. After the sixteenth word the engine
// runs 64 rounds, one per cycle, through a single round unit fed by a
// sixteen-cell schedule line that shifts and expands W16..W79 in step with the
// rounds. It then offers the eight chaining words V0..V7, one per cycle while
// the sink is ready, with tlast on V7. The input side is held off during
// rounds and output, so a new block is taken only after V7 has gone.
// Padding and length encoding belong to software.
// ----------------------------------------------------------------------------
`include "sm3_compression_macros.svh"

module sm3_compression
  import sm3c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] message_word
  input  logic [0:0]  s_tuser,    // [0] opcode
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] digest_word
  output logic        m_tlast     // digest_last
);

  fsm_t        state, state_next;
  logic [3:0]  word_count;
  logic [5:0]  round_count;
  logic [2:0]  out_idx;
  state_vec_t  chain;
  state_vec_t  working;
  state_vec_t  round_next;
  window_t     win;
  sched_ctrl_t sched_ctrl;
  logic        in_acc, out_acc, is_restart, block_done, rounds_done;

  assign is_restart  = (opcode_t'(s_tuser[0]) == OP_RESTART);
  assign in_acc      = s_tvalid && s_tready;
  assign out_acc     = m_tvalid && m_tready;
  assign block_done  = in_acc && !is_restart && (word_count == 4'(WORDS_PER_BLOCK - 1));
  assign rounds_done = (state == S_ROUND) && (round_count == 6'(ROUNDS - 1));

  // schedule line: shifts on every loaded word and every round
  assign sched_ctrl.shift  = (in_acc && !is_restart) || (state == S_ROUND);
  assign sched_ctrl.expand = (state == S_ROUND);

  sm3c_sched u_sched (
    .clk       (clk),
    .ctrl      (sched_ctrl),
    .load_word (s_tdata),
    .win       (win)
  );

  // round j sees W[j] in cell 0 and W[j+4] in cell 4
  sm3c_round u_round (
    .cur  (working),
    .r    (round_count),
    .w_j  (win[0]),
    .w_j4 (win[4]),
    .nxt  (round_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (block_done) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rounds_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready && (out_idx == 3'(DIGEST_WORDS - 1))) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // counters and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count  <= '0;
      round_count <= '0;
      out_idx     <= '0;
      chain       <= SM3_IV;
    end else begin
      if (in_acc) begin
        if (is_restart) begin
          word_count <= '0;
          chain      <= SM3_IV;
        end else begin
          word_count <= word_count + 4'd1;   // wraps to zero after word sixteen
        end
      end
      if (state == S_ROUND) begin
        round_count <= round_count + 6'd1;   // wraps to zero after round 63
      end
      if (rounds_done) begin
        chain <= chain ^ round_next;
      end
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  // A..H: loaded from the chaining value at block start
  always_ff @(posedge clk) begin
    if (block_done) begin
      working <= chain;
    end else if (state == S_ROUND) begin
      working <= round_next;
    end
  end

  assign m_tdata = chain[out_idx];
  assign m_tlast = m_tvalid && (out_idx == 3'(DIGEST_WORDS - 1));

  `SM3_ASSERT_IMPL(a_one_side, clk, rst, m_tvalid, !s_tready, "input open during output")
  `SM3_ASSERT_NEXT(a_block_start, clk, rst, block_done, (state == S_ROUND) && (round_count == 6'd0), "block did not start rounds")
  `SM3_ASSERT_NEXT(a_round_end, clk, rst, rounds_done, m_tvalid && (out_idx == 3'd0), "rounds did not end in output")
  `SM3_ASSERT_NEXT(a_out_end, clk, rst, out_acc && m_tlast, s_tready && (word_count == 4'd0), "output did not return to load")

endmodule

>>> dv/tb_sm3_compression.sv
// ----------------------------------------------------------------------------
// SM3 compression engine testbench
// Sends 512-bit blocks as 32-bit word items, with restarts in between,
// predicts each chaining value with a behavioral SM3 compression function and
// checks every digest item in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sm3_compression;
  import sm3c_pkg::*;

  // watchdog bound, well above the run time of a correct run
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // cycles to wait after the last digest item
  localparam int unsigned DRAIN_CYCLES = 100;
  // random items per idling phase, three phases
  localparam int unsigned PHASE_ITEMS  = 105;
  localparam int unsigned SINK_STALL   = 400;
  localparam int unsigned NUM_DIRECTED = 22;

  // how the words of a random block are chosen
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_MIXED
  } fill_t;

  // one row of the directed table
  typedef struct packed {
    opcode_t op;
    word_t   data;
  } stim_row_t;

  // one expected digest item
  typedef struct packed {
    word_t word;
    logic  last;
  } digest_item_t;

  // standard SM3 initial value, V0 first
  localparam word_t IV_WORDS [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] message_word
  logic [0:0]  s_tuser  = '0;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [31:0] digest_word
  logic        m_tlast;         // digest_last

  // predictor state: chaining value and the words of the block being filled
  word_t        chain_v [8];
  word_t        blk_words [16];
  int unsigned  words_held;

  // digest items still to come, oldest first
  digest_item_t digest_q [$];
  digest_item_t want;

  int unsigned  err_cnt    = 0;
  int unsigned  cycle_cnt  = 0;
  int unsigned  sent_items = 0;
  int unsigned  snd_idle_pct = 0;
  int unsigned  rcv_idle_pct = 0;
  logic         sink_hold  = 1'b0;

  stim_row_t    dir_rows [NUM_DIRECTED];

  sm3_compression dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // SM3 predictor
  // --------------------------------------------------------------------------

  // rotate left; a count of zero (mod 32) leaves the word alone
  function automatic word_t rol(input word_t x, input int unsigned n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t p0_of(input word_t x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic word_t p1_of(input word_t x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // one compression of the buffered block into the chaining value; the new
  // chaining value goes onto the digest queue, V7 flagged last
  function automatic void compress_block();
    word_t w [68];
    word_t wp [64];
    word_t v [8];
    word_t a12, ss1, ss2, tt1, tt2, tc, ffv, ggv;
    digest_item_t d;
    for (int i = 0; i < 16; i++) w[i] = blk_words[i];
    for (int i = 16; i < 68; i++)
      w[i] = p1_of(w[i-16] ^ w[i-9] ^ rol(w[i-3], 15)) ^ rol(w[i-13], 7) ^ w[i-6];
    for (int i = 0; i < 64; i++) wp[i] = w[i] ^ w[i+4];
    for (int i = 0; i < 8; i++) v[i] = chain_v[i];
    for (int r = 0; r < 64; r++) begin
      tc  = (r < 16) ? T_LOW : T_HIGH;
      a12 = rol(v[0], 12);
      // constant rotation wraps: rounds 0 and 32 use it unrotated
      ss1 = rol(a12 + v[4] + rol(tc, r), 7);
      ss2 = ss1 ^ a12;
      if (r < 16) begin
        ffv = v[0] ^ v[1] ^ v[2];
        ggv = v[4] ^ v[5] ^ v[6];
      end else begin
        ffv = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        ggv = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ffv + v[3] + ss2 + wp[r];
      tt2 = ggv + v[7] + ss1 + w[r];
      v[3] = v[2];
      v[2] = rol(v[1], 9);
      v[1] = v[0];
      v[0] = tt1;
      v[7] = v[6];
      v[6] = rol(v[5], 19);
      v[5] = v[4];
      v[4] = p0_of(tt2);
    end
    for (int i = 0; i < 8; i++) begin
      chain_v[i] = chain_v[i] ^ v[i];
      d.word = chain_v[i];
      d.last = (i == 7);
      digest_q.push_back(d);
    end
  endfunction

  // advance the predictor by one accepted input item
  function automatic void absorb_item(input opcode_t op, input word_t data);
    if (op == OP_RESTART) begin
      // back to IV, partial block dropped, no digest
      for (int i = 0; i < 8; i++) chain_v[i] = IV_WORDS[i];
      words_held = 0;
    end else begin
      blk_words[words_held] = data;
      words_held++;
      if (words_held == 16) begin
        words_held = 0;
        compress_block();
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic flag_error(input string what, input word_t got, input word_t exp_v);
    $display("ERROR cycle %0d: %s got %08h want %08h", cycle_cnt, what, got, exp_v);
    err_cnt++;
  endtask

  // Sink side: values read right after the edge are the ones the DUT saw at
  // that edge, since all drives here are nonblocking. m_tready gets exactly
  // one assignment per edge; the hold flag forces a long stall.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        flag_error("digest item with none expected", m_tdata, '0);
      end else begin
        want = digest_q.pop_front();
        if (m_tdata !== want.word) flag_error("digest_word", m_tdata, want.word);
        if (m_tlast !== want.last) begin
          flag_error("digest_last", word_t'(m_tlast), word_t'(want.last));
        end
      end
    end
    m_tready <= !sink_hold && ($urandom_range(99) >= rcv_idle_pct);
  end

  // run-time watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // Offer one item and wait for the handshake. tvalid stays high from the
  // previous item when no gap is taken, so it is never lowered and raised in
  // the same step.
  task automatic send_item(input opcode_t op, input word_t data);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_item(op, data);
    sent_items++;
  endtask

  // long sink stall, timed in its own process
  task automatic hold_sink(input int unsigned n);
    sink_hold <= 1'b1;
    repeat (n) @(posedge clk);
    sink_hold <= 1'b0;
  endtask

  function automatic word_t pick_word(input fill_t fill);
    case (fill)
      FILL_ZERO: return '0;
      FILL_ONES: return '1;
      FILL_MIXED: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return word_t'(1) << $urandom_range(31);
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_words(input fill_t fill, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(OP_MESSAGE, pick_word(fill));
  endtask

  // drop tvalid so the last item is not offered again, then wait until every
  // predicted digest item has come back
  task automatic drain_digests();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned goal;
    int unsigned pick;
    fill_t       fill;

    for (int i = 0; i < 8; i++) chain_v[i] = IV_WORDS[i];
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    words_held = 0;

    // Directed part: restart with an all-ones (ignored) word, a partial block of
    // extremes dropped by a second restart, the padded "abc" block, a restart.
    dir_rows = '{
      '{OP_RESTART, 32'hFFFFFFFF},
      '{OP_MESSAGE, 32'h00000000},
      '{OP_MESSAGE, 32'hFFFFFFFF},
      '{OP_MESSAGE, 32'h80000000},
      '{OP_RESTART, 32'h00000000},
      '{OP_MESSAGE, 32'h61626380},
      '{OP_MESSAGE, 32'h00000000}, '{OP_MESSAGE, 32'h00000000},
      '{OP_MESSAGE, 32'h00000000}, '{OP_MESSAGE, 32'h00000000},
      '{OP_MESSAGE, 32'h00000000}, '{OP_MESSAGE, 32'h00000000},
      '{OP_MESSAGE, 32'h00000000}, '{OP_MESSAGE, 32'h00000000},
      '{OP_MESSAGE, 32'h00000000}, '{OP_MESSAGE, 32'h00000000},
      '{OP_MESSAGE, 32'h00000000}, '{OP_MESSAGE, 32'h00000000},
      '{OP_MESSAGE, 32'h00000000}, '{OP_MESSAGE, 32'h00000000},
      '{OP_MESSAGE, 32'h00000018},
      '{OP_RESTART, 32'h5A5A5A5A}
    };

    // first idling phase: sender rarely idles, sink mostly stalls
    snd_idle_pct = 6;
    rcv_idle_pct = 82;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) send_item(dir_rows[i].op, dir_rows[i].data);

    // Random part, three idling phases. Mostly whole blocks with random
    // content; some blocks broken off by a restart, some lone restarts.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        1: begin
          snd_idle_pct = 82;
          rcv_idle_pct = 6;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          // sink stalls while the sender keeps offering: the engine fills up
          // and holds off its input
          fork
            hold_sink(SINK_STALL);
          join_none
        end
        default: ;
      endcase
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        pick = $urandom_range(99);
        case ($urandom_range(19))
          0:       fill = FILL_ZERO;
          1:       fill = FILL_ONES;
          2, 3, 4: fill = FILL_MIXED;
          default: fill = FILL_RANDOM;
        endcase
        if (pick < 80) begin
          send_words(fill, 16);
        end else if (pick < 92) begin
          send_words(fill, $urandom_range(15, 1));
          send_item(OP_RESTART, $urandom);
        end else begin
          send_item(OP_RESTART, $urandom);
        end
      end
      // sender pauses until the engine has handed back everything
      drain_digests();
    end

    drain_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/sm3c_pkg.sv
rtl/sm3c_wcell.sv
rtl/sm3c_sched.sv
rtl/sm3c_round.sv
rtl/sm3_compression.sv
dv/tb_sm3_compression.sv
